[design/fuzzy_steering_controller_defines.svh]
// ----------------------------------------------------------------------------
// Fuzzy steering controller assertion macros
// Shared concurrent assertion forms clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FUZZY_STEERING_CONTROLLER_DEFINES_SVH
`define FUZZY_STEERING_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define FSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fuzzy steering controller assertion failed");

// Next-cycle implication.
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fuzzy steering controller assertion failed");

`endif

[design/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// Fuzzy steering controller package
// Membership set geometry, rule table and consequent coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

    localparam int NUM_X_SETS = 5;
    localparam int NUM_H_SETS = 7;
    localparam int NUM_SETS   = NUM_X_SETS + NUM_H_SETS;
    localparam int Q8_SCALE   = 256;
    localparam int ANGLE_MAX  = 6400;
    localparam int QUOT_BITS  = 13;

    // Position sets LE..RI come first, then heading sets RB..LB. Feet in degrees.
    localparam int SET_LO[NUM_SETS] = '{0, 30, 45, 50, 65,
                                        -110, -10, 40, 80, 90, 130, 165};
    localparam int SET_HI[NUM_SETS] = '{35, 50, 55, 70, 0,
                                        10, 60, 90, 100, 140, 190, 280};
    localparam int SET_HAS_LO[NUM_SETS] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
    localparam int SET_HAS_HI[NUM_SETS] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1};
    localparam int SET_W[NUM_SETS] = '{25, 10, 5, 10, 25,
                                       55, 35, 25, 10, 25, 30, 60};

    localparam int RULE_CODE[NUM_H_SETS][NUM_X_SETS] = '{
        '{5, 6, 6, 7, 7},
        '{3, 5, 6, 7, 7},
        '{2, 3, 5, 6, 7},
        '{2, 2, 4, 6, 6},
        '{1, 2, 3, 5, 6},
        '{1, 1, 2, 3, 5},
        '{1, 1, 2, 2, 3}
    };

    // Twice the consequent angle is slope * w + offset, w in units of one.
    localparam int CONS_SLOPE[8]  = '{0, -15, -20, -12, 0, 0, 0, 15};
    localparam int CONS_OFFSET[8] = '{0, -15, -30, -12, 0, 12, 31, 15};

endpackage

`default_nettype wire

[design/fuzzy_steering_controller.sv]
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while a finished result waits on m_ready.
// Reset (synchronous, active low) clears every stage valid bit; the data
// registers are not reset.
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy steering controller
// Product-inference fuzzy controller with weighted-average defuzzification,
// built as a deep pipeline ending in a one-bit-per-stage restoring divider and an output register.
// ----------------------------------------------------------------------------
`include "fuzzy_steering_controller_defines.svh"

module fuzzy_steering_controller
    import fsc_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [14:0] s_x_pos,
    input  wire logic signed [17:0] s_heading,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [13:0]      m_steer_angle,
    output logic                    m_steer_valid
);

    localparam int F    = FRAC_BITS;
    localparam int DSTW = 20;
    localparam int TW   = F + 6;
    localparam int RS   = F + 12;
    localparam int GW   = F + 1;
    localparam int WQW  = 2 * GW;
    localparam int NW   = 2 * F + 12;
    localparam int DENW = F + 7;
    localparam int NNW  = 2 * F + 20;
    localparam int NDIV = QUOT_BITS;
    localparam int NST  = 11 + NDIV;

    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv     = !vld_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // Stage 0: input capture.
    logic        [14:0] x_reg;
    logic signed [17:0] h_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= s_x_pos;
            h_reg <= s_heading;
        end
    end

    // Stage 1: distance to the set foot, pre-scaled, with clamp flags.
    logic [TW-1:0] t_reg    [NUM_SETS];
    logic          zero_reg [NUM_SETS];
    logic          one_reg  [NUM_SETS];
    logic [TW-1:0] t_next   [NUM_SETS];
    logic          zero_next[NUM_SETS];
    logic          one_next [NUM_SETS];

    always_comb begin
        logic signed [DSTW-1:0] v;
        logic signed [DSTW-1:0] dlo;
        logic signed [DSTW-1:0] dhi;
        logic signed [DSTW-1:0] span;
        logic [DSTW+F-1:0]      sh;
        for (int i = 0; i < NUM_SETS; i++) begin
            if (i < NUM_X_SETS) begin
                v = DSTW'({5'b0, x_reg});
            end else begin
                v = DSTW'(h_reg);
            end
            dlo = v - DSTW'(SET_LO[i] * Q8_SCALE);
            dhi = DSTW'(SET_HI[i] * Q8_SCALE) - v;
            if (SET_HAS_LO[i] != 0 && SET_HAS_HI[i] != 0) begin
                span = (dlo < dhi) ? dlo : dhi;
            end else if (SET_HAS_LO[i] != 0) begin
                span = dlo;
            end else begin
                span = dhi;
            end
            sh           = {span, {F{1'b0}}};
            t_next[i]    = TW'(sh >> 8);
            zero_next[i] = span[DSTW-1] || (span == '0);
            one_next[i]  = span >= DSTW'(SET_W[i] * Q8_SCALE);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg    <= t_next;
            zero_reg <= zero_next;
            one_reg  <= one_next;
        end
    end

    // Stage 2: grade = t / width through an exact rounded-up reciprocal.
    logic [GW-1:0] grade_reg [NUM_SETS];
    logic [GW-1:0] grade_next[NUM_SETS];

    for (genvar gi = 0; gi < NUM_SETS; gi++) begin : g_grade
        localparam logic [RS:0] RECIP = (RS+1)'(((64'd1 << RS) + 64'(SET_W[gi]) - 64'd1)
                                                / 64'(SET_W[gi]));
        logic [TW+RS:0] prod;
        assign prod = (TW+RS+1)'(t_reg[gi]) * (TW+RS+1)'(RECIP);
        always_comb begin
            if (one_reg[gi]) begin
                grade_next[gi] = GW'(1) << F;
            end else if (zero_reg[gi]) begin
                grade_next[gi] = '0;
            end else begin
                grade_next[gi] = GW'(prod >> RS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            grade_reg <= grade_next;
        end
    end

    // Stage 3: rule weights.
    logic [GW-1:0] w3_reg [NUM_H_SETS][NUM_X_SETS];
    logic [GW-1:0] w3_next[NUM_H_SETS][NUM_X_SETS];

    always_comb begin
        logic [WQW-1:0] p;
        for (int r = 0; r < NUM_H_SETS; r++) begin
            for (int c = 0; c < NUM_X_SETS; c++) begin
                p = WQW'(grade_reg[c]) * WQW'(grade_reg[NUM_X_SETS + r]);
                w3_next[r][c] = GW'(p >> F);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w3_reg <= w3_next;
        end
    end

    // Stage 4: squared weights.
    logic [GW-1:0]  w4_reg  [NUM_H_SETS][NUM_X_SETS];
    logic [WQW-1:0] wsq_reg [NUM_H_SETS][NUM_X_SETS];
    logic [WQW-1:0] wsq_next[NUM_H_SETS][NUM_X_SETS];

    always_comb begin
        for (int r = 0; r < NUM_H_SETS; r++) begin
            for (int c = 0; c < NUM_X_SETS; c++) begin
                wsq_next[r][c] = WQW'(w3_reg[r][c]) * WQW'(w3_reg[r][c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w4_reg  <= w3_reg;
            wsq_reg <= wsq_next;
        end
    end

    // Stage 5: numerator term w * twice_angle = slope * w^2 + offset * w * one.
    logic signed [NW-1:0] term_reg [NUM_H_SETS][NUM_X_SETS];
    logic signed [NW-1:0] term_next[NUM_H_SETS][NUM_X_SETS];
    logic [GW-1:0]        w5_reg   [NUM_H_SETS][NUM_X_SETS];

    always_comb begin
        logic signed [NW-1:0] a;
        logic signed [NW-1:0] b;
        for (int r = 0; r < NUM_H_SETS; r++) begin
            for (int c = 0; c < NUM_X_SETS; c++) begin
                a = NW'(wsq_reg[r][c]);
                b = NW'(w4_reg[r][c]) <<< F;
                term_next[r][c] = NW'(CONS_SLOPE[RULE_CODE[r][c]]) * a
                                + NW'(CONS_OFFSET[RULE_CODE[r][c]]) * b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            term_reg <= term_next;
            w5_reg   <= w4_reg;
        end
    end

    // Stage 6: per-row sums.
    logic signed [NW-1:0] rnum_reg [NUM_H_SETS];
    logic [DENW-1:0]      rden_reg [NUM_H_SETS];
    logic signed [NW-1:0] rnum_next[NUM_H_SETS];
    logic [DENW-1:0]      rden_next[NUM_H_SETS];

    always_comb begin
        for (int r = 0; r < NUM_H_SETS; r++) begin
            rnum_next[r] = '0;
            rden_next[r] = '0;
            for (int c = 0; c < NUM_X_SETS; c++) begin
                rnum_next[r] = rnum_next[r] + term_reg[r][c];
                rden_next[r] = rden_next[r] + DENW'(w5_reg[r][c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rnum_reg <= rnum_next;
            rden_reg <= rden_next;
        end
    end

    // Stage 7: totals.
    logic signed [NW-1:0] num_reg;
    logic [DENW-1:0]      den_reg;
    logic signed [NW-1:0] num_next;
    logic [DENW-1:0]      den_next;

    always_comb begin
        num_next = '0;
        den_next = '0;
        for (int r = 0; r < NUM_H_SETS; r++) begin
            num_next = num_next + rnum_reg[r];
            den_next = den_next + rden_reg[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // Stage 8: rounded dividend and divisor, quotient = N / D.
    logic [NNW-1:0] n8_reg;
    logic [NNW-1:0] d8_reg;
    logic           neg8_reg;
    logic           nz8_reg;
    logic [NW-1:0]  mag;
    logic [NNW-1:0] dsc;

    assign mag = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign dsc = NNW'(den_reg) << F;

    always_ff @(posedge aclk) begin
        if (adv) begin
            n8_reg   <= (NNW'(mag) << 8) + dsc;
            d8_reg   <= dsc << 1;
            neg8_reg <= num_reg[NW-1];
            nz8_reg  <= (den_reg != '0);
        end
    end

    // Stage 9: saturation check, quotient above the limit iff N >= (limit+1) * D.
    logic [NNW-1:0] rem_reg [NDIV+1];
    logic [NNW-1:0] dv_reg  [NDIV+1];
    logic [NDIV-1:0] q_reg  [NDIV+1];
    logic           neg_reg [NDIV+1];
    logic           nz_reg  [NDIV+1];
    logic           sat_reg [NDIV+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= n8_reg;
            dv_reg[0]  <= d8_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg8_reg;
            nz_reg[0]  <= nz8_reg;
            sat_reg[0] <= n8_reg >= NNW'(d8_reg * NNW'(ANGLE_MAX + 1));
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int K = NDIV - 1 - j;
        logic [NNW-1:0] cmp;
        logic           ge;
        assign cmp = dv_reg[j] << K;
        assign ge  = rem_reg[j] >= cmp;
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j+1] <= ge ? (rem_reg[j] - cmp) : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (NDIV'(ge) << K);
                dv_reg[j+1]  <= dv_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                nz_reg[j+1]  <= nz_reg[j];
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    // Output word register.
    logic [NDIV-1:0]    qm;
    logic signed [13:0] angle_next;

    assign qm = sat_reg[NDIV] ? NDIV'(ANGLE_MAX) : q_reg[NDIV];

    always_comb begin
        if (!nz_reg[NDIV]) begin
            angle_next = '0;
        end else if (neg_reg[NDIV]) begin
            angle_next = -$signed(14'(qm));
        end else begin
            angle_next = $signed(14'(qm));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_steer_angle <= angle_next;
            m_steer_valid <= nz_reg[NDIV];
        end
    end

    `FSC_ASSERT_SAME(a_no_fire_zero, m_valid && !m_steer_valid, m_steer_angle == 14'sd0)
    `FSC_ASSERT_SAME(a_angle_range, m_valid,
        (m_steer_angle <= 14'sd6400) && (m_steer_angle >= -14'sd6400))
    `FSC_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, vld_reg[0])
    `FSC_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, m_valid && $stable(vld_reg))

endmodule

`default_nettype wire

[dv/fuzzy_steering_controller_test.sv]
// ----------------------------------------------------------------------------
// Fuzzy steering controller testbench
// Drives position and heading words with random idling on both channels and
// checks every steering result against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_steering_controller_test
    import fsc_pkg::*;
();

    localparam int FRAC = 8;
    localparam longint ONE_G = 64'sd1 << FRAC;
    localparam int LATENCY = 23;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [13:0] angle;
        logic               fired;
    } steer_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic        [14:0] s_x_pos = '0;
    logic signed [17:0] s_heading = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [13:0] m_steer_angle;
    logic               m_steer_valid;

    steer_t expected_steer[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     calm_phase = 1'b0;

    fuzzy_steering_controller #(.FRAC_BITS(FRAC)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_pos       (s_x_pos),
        .s_heading     (s_heading),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_steer_angle (m_steer_angle),
        .m_steer_valid (m_steer_valid)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint membership(longint dist_q8, longint width);
        longint m;
        if (dist_q8 <= 0) return 0;
        m = (dist_q8 * ONE_G) / (width * 256);
        return (m > ONE_G) ? ONE_G : m;
    endfunction

    function automatic longint lesser(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic steer_t predict_steer(logic [14:0] xp, logic signed [17:0] hd);
        longint x, h, num, den, w, twice, d, mag, qm;
        longint gx[5];
        longint gh[7];
        int code;
        steer_t res;
        x = longint'(xp);
        h = longint'(hd);
        num = 0;
        den = 0;
        gx[0] = membership(35 * 256 - x, 25);
        gx[1] = membership(lesser(x - 30 * 256, 50 * 256 - x), 10);
        gx[2] = membership(lesser(x - 45 * 256, 55 * 256 - x), 5);
        gx[3] = membership(lesser(x - 50 * 256, 70 * 256 - x), 10);
        gx[4] = membership(x - 65 * 256, 25);
        gh[0] = membership(lesser(h + 110 * 256, 10 * 256 - h), 55);
        gh[1] = membership(lesser(h + 10 * 256, 60 * 256 - h), 35);
        gh[2] = membership(lesser(h - 40 * 256, 90 * 256 - h), 25);
        gh[3] = membership(lesser(h - 80 * 256, 100 * 256 - h), 10);
        gh[4] = membership(lesser(h - 90 * 256, 140 * 256 - h), 25);
        gh[5] = membership(lesser(h - 130 * 256, 190 * 256 - h), 30);
        gh[6] = membership(lesser(h - 165 * 256, 280 * 256 - h), 60);
        for (int r = 0; r < 7; r++) begin
            for (int c = 0; c < 5; c++) begin
                w = (gx[c] * gh[r]) >>> FRAC;
                code = RULE_CODE[r][c];
                twice = longint'(CONS_SLOPE[code]) * w + longint'(CONS_OFFSET[code]) * ONE_G;
                num += w * twice;
                den += w;
            end
        end
        res.angle = '0;
        res.fired = (den != 0);
        if (den != 0) begin
            d = den * ONE_G;
            mag = (num < 0) ? -num : num;
            qm = (mag * 256 + d) / (2 * d);
            if (qm > longint'(ANGLE_MAX)) qm = longint'(ANGLE_MAX);
            res.angle = 14'((num < 0) ? -qm : qm);
        end
        return res;
    endfunction

    // Sends one word, with a random gap first unless in a calm phase.
    task automatic send_word(logic [14:0] xp, logic signed [17:0] hd);
        if (!calm_phase) begin
            while ($urandom_range(99) < 30) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_x_pos <= xp;
        s_heading <= hd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_steer.push_back(predict_steer(xp, hd));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_steer.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fuzzy_steering_controller_test: errors");
            $finish;
        end
        if (aresetn) m_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin
        steer_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_steer.size() == 0) begin
                $display("%0t: unexpected word angle=%0d valid=%0d", $time,
                         m_steer_angle, m_steer_valid);
                error_count++;
            end else begin
                e = expected_steer.pop_front();
                if (m_steer_angle !== e.angle) begin
                    $display("%0t: steer_angle expected %0d actual %0d", $time,
                             e.angle, m_steer_angle);
                    error_count++;
                end
                if (m_steer_valid !== e.fired) begin
                    $display("%0t: steer_valid expected %0d actual %0d", $time,
                             e.fired, m_steer_valid);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        int xs[] = '{0, 3200, 7680, 11520, 12800, 14080, 17920, 25600, 32767};
        int hs[] = '{-23040, -131072, 0, 23040, 25600, 46080, 69120, 131071};
        foreach (xs[i]) send_word(15'(xs[i]), 18'sd23040);
        foreach (hs[i]) send_word(15'd12800, 18'(hs[i]));
        // Far outside every heading set, so no rule fires.
        send_word(15'd12800, 18'sd100000);
        send_word(15'd0, -18'sd60000);
        send_word(15'h7fff, 18'sh20000);
        send_word(15'h5555, 18'sh15555);
        send_word(15'h2aaa, 18'sh2aaaa);
    endtask

    task automatic test_random();
        for (int i = 0; i < 1100; i++) begin
            calm_phase = (i >= 400 && i < 500);
            if (i == 700) wait_drained();
            if ($urandom_range(9) == 0)
                send_word(15'($urandom), 18'($urandom));
            else
                send_word(15'($urandom_range(25600)),
                          18'(int'($urandom_range(92160)) - 23040));
        end
        calm_phase = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        wait_drained();
        repeat (LATENCY * 2) @(posedge aclk);
        if (error_count == 0)
            $display("fuzzy_steering_controller_test: clean");
        else
            $display("fuzzy_steering_controller_test: errors");
        $finish;
    end

endmodule

`default_nettype wire

[fuzzy_steering_controller.f]
+incdir+design
design/fsc_pkg.sv
design/fuzzy_steering_controller.sv
dv/fuzzy_steering_controller_test.sv
